FILE: src/netstring_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// netstring deframer assertion macros
// shared concurrent check forms for the deframer top level
// ----------------------------------------------------------------------------
`ifndef NETSTRING_DEFRAMER_CORE_ASSERT_SVH
`define NETSTRING_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NSDF_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("netstring deframer check failed");

// next-cycle implication, checked out of reset
`define NSDF_ASSERT_NXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("netstring deframer sequence check failed");

`endif

FILE: src/nsdf_pkg.sv
// ----------------------------------------------------------------------------
// nsdf_pkg
// shared types, codes and constants of the netstring deframer
// ----------------------------------------------------------------------------
`default_nettype none

package nsdf_pkg;

    // default length field limit in decimal digits
    localparam int MAX_DIGITS_DEF = 20;

    // configuration port geometry (64-bit registers at 8-byte spacing)
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // register indexes
    localparam logic [1:0] REG_FRAME_LIMIT_ON  = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_TOTAL_LEN   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BAD_CHAR    = 4'd1;
    localparam logic [3:0] ERR_MANY_DIGITS = 4'd2;
    localparam logic [3:0] ERR_LEN_OVF     = 4'd3;
    localparam logic [3:0] ERR_LEAD_ZERO   = 4'd4;
    localparam logic [3:0] ERR_OVER_LIMIT  = 4'd5;
    localparam logic [3:0] ERR_TOTAL_OVF   = 4'd6;
    localparam logic [3:0] ERR_OVER_TOTAL  = 4'd7;
    localparam logic [3:0] ERR_BAD_TERM    = 4'd8;

    // ascii characters of the framing
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // configuration register set
    typedef struct packed {
        logic        frame_limit_on;
        logic [63:0] max_payload_len;
        logic [63:0] max_total_len;
    } nsdf_cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [63:0] frame_len;
        logic [3:0]  error_code;
    } nsdf_result_t;

endpackage

`default_nettype wire

FILE: src/nsdf_if.sv
// ----------------------------------------------------------------------------
// nsdf stream interfaces
// valid/ready channels for raw bytes in and result items out
// ----------------------------------------------------------------------------
`default_nettype none

// raw byte channel
interface nsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// result item channel
interface nsdf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] frame_len;
    logic [3:0]  error_code;

    modport source (output valid, output kind, output payload_byte, output frame_len,
                    output error_code, input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_len,
                  input error_code, output ready);
endinterface

`default_nettype wire

FILE: src/nsdf_cfg_regs.sv
// ----------------------------------------------------------------------------
// nsdf_cfg_regs
// apb register file holding the length limits
// ----------------------------------------------------------------------------
`default_nettype none

module nsdf_cfg_regs
    import nsdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output nsdf_cfg_t              cfg
);

    nsdf_cfg_t  cfg_reg;
    nsdf_cfg_t  cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_LIMIT_ON:  cfg_next.frame_limit_on  = pwdata[0];
                REG_MAX_PAYLOAD_LEN: cfg_next.max_payload_len = pwdata;
                REG_MAX_TOTAL_LEN:   cfg_next.max_total_len   = pwdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_FRAME_LIMIT_ON:  prdata = {63'd0, cfg_reg.frame_limit_on};
            REG_MAX_PAYLOAD_LEN: prdata = cfg_reg.max_payload_len;
            REG_MAX_TOTAL_LEN:   prdata = cfg_reg.max_total_len;
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/nsdf_parser.sv
// ----------------------------------------------------------------------------
// nsdf_parser
// input byte register, parse state and per-byte decision logic
// ----------------------------------------------------------------------------
`default_nettype none

module nsdf_parser
    import nsdf_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire nsdf_cfg_t    cfg,
    nsdf_in_if.sink           stream,
    input  wire logic         slot_free,
    output logic              take,
    output logic              res_valid,
    output nsdf_result_t      res,
    output logic              halted
);

    localparam int DCW = $clog2(MAX_DIGITS + 1);

    // parse phases
    localparam logic [1:0] PH_DIGITS  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TERM    = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    logic           hold_valid_reg;
    logic           hold_valid_next;
    logic [7:0]     hold_byte_reg;
    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [63:0]    acc_reg;
    logic [63:0]    acc_next;
    logic [DCW-1:0] dcount_reg;
    logic [DCW-1:0] dcount_next;
    logic           fzero_reg;
    logic           fzero_next;
    logic [63:0]    left_reg;
    logic [63:0]    left_next;

    logic           accept;
    logic [7:0]     c;
    logic [3:0]     digit;
    logic           is_digit;
    logic [67:0]    acc_x10;
    logic [64:0]    total;

    // input register: refills in the cycle it drains
    assign take         = hold_valid_reg && slot_free;
    assign stream.ready = !hold_valid_reg || take;
    assign accept       = stream.valid && stream.ready;
    assign halted       = (phase_reg == PH_HALT);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= stream.in_byte;
        end
    end

    // datapath terms
    assign c        = hold_byte_reg;
    assign digit    = 4'(c - CH_ZERO);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, digit};
    assign total    = {1'b0, acc_reg} + 65'(dcount_reg) + 65'd2;

    // per-byte decision
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        dcount_next = dcount_reg;
        fzero_next  = fzero_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = KIND_ERR;
        case (phase_reg)
            PH_DIGITS:
            begin
                if (c == CH_COLON)
                begin
                    res_valid = 1'b1;
                    if (dcount_reg == '0)
                    begin
                        res.error_code = ERR_BAD_CHAR;
                    end
                    else if ((dcount_reg > DCW'(1)) && fzero_reg)
                    begin
                        res.error_code = ERR_LEAD_ZERO;
                    end
                    else if (cfg.frame_limit_on && (acc_reg > cfg.max_payload_len))
                    begin
                        res.error_code = ERR_OVER_LIMIT;
                    end
                    else if (total[64])
                    begin
                        res.error_code = ERR_TOTAL_OVF;
                    end
                    else if ((cfg.max_total_len != '0) &&
                             (total[63:0] > cfg.max_total_len))
                    begin
                        res.error_code = ERR_OVER_TOTAL;
                    end
                    else
                    begin
                        res_valid = 1'b0;
                        left_next = acc_reg;
                        phase_next = (acc_reg == '0) ? PH_TERM : PH_PAYLOAD;
                    end
                    if (res_valid)
                    begin
                        phase_next = PH_HALT;
                    end
                end
                else if (!is_digit)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_BAD_CHAR;
                    phase_next     = PH_HALT;
                end
                else if (dcount_reg >= DCW'(MAX_DIGITS))
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_MANY_DIGITS;
                    phase_next     = PH_HALT;
                end
                else if (acc_x10[67:64] != 4'd0)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_LEN_OVF;
                    phase_next     = PH_HALT;
                end
                else
                begin
                    acc_next    = acc_x10[63:0];
                    dcount_next = dcount_reg + DCW'(1);
                    if ((dcount_reg == '0) && (digit == 4'd0))
                    begin
                        fzero_next = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_BYTE;
                res.payload_byte = c;
                left_next        = left_reg - 64'd1;
                if (left_reg == 64'd1)
                begin
                    phase_next = PH_TERM;
                end
            end
            PH_TERM:
            begin
                res_valid = 1'b1;
                if (c != CH_COMMA)
                begin
                    res.error_code = ERR_BAD_TERM;
                    phase_next     = PH_HALT;
                end
                else
                begin
                    res.kind      = KIND_DONE;
                    res.frame_len = acc_reg;
                    acc_next      = '0;
                    dcount_next   = '0;
                    fzero_next    = 1'b0;
                    left_next     = '0;
                    phase_next    = PH_DIGITS;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // parse state, updated once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DIGITS;
            acc_reg    <= '0;
            dcount_reg <= '0;
            fzero_reg  <= 1'b0;
            left_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            dcount_reg <= dcount_next;
            fzero_reg  <= fzero_next;
            left_reg   <= left_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/nsdf_out_reg.sv
// ----------------------------------------------------------------------------
// nsdf_out_reg
// result register driving the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module nsdf_out_reg
    import nsdf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire logic         res_valid,
    input  wire nsdf_result_t res,
    output logic              slot_free,
    nsdf_out_if.source        result
);

    logic         valid_reg;
    logic         valid_next;
    nsdf_result_t data_reg;

    // slot opens when empty or when the held result transfers now
    assign slot_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = res_valid;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = data_reg.kind;
    assign result.payload_byte = data_reg.payload_byte;
    assign result.frame_len    = data_reg.frame_len;
    assign result.error_code   = data_reg.error_code;

endmodule

`default_nettype wire

FILE: src/netstring_deframer_core.sv
// ----------------------------------------------------------------------------
// netstring_deframer_core
// Streaming netstring decoder taking one byte per clock cycle while the
// result channel is ready, through an input byte register, combinational
// parse logic and a result register; a result is registered once its byte
// leaves the input byte register. Each payload byte comes out as a byte
// item, a correct closing comma gives a frame-complete item with the length,
// and the first framing error is reported once, after which the block
// swallows all bytes until reset. Length digits and the colon give no item.
// The user sets limits over the APB port while the stream is idle; the block
// does not enforce this. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "netstring_deframer_core_assert.svh"

module netstring_deframer_core
    import nsdf_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    nsdf_in_if.sink                stream,
    nsdf_out_if.source             result
);

    nsdf_cfg_t    cfg;
    nsdf_result_t res;
    logic         res_valid;
    logic         take;
    logic         slot_free;
    logic         halted;

    // configuration registers
    nsdf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parse stage
    nsdf_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stream    (stream),
        .slot_free (slot_free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .halted    (halted)
    );

    // result register
    nsdf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .result    (result)
    );

    // once halted the parser produces nothing further
    `NSDF_ASSERT_NXT(a_halt_silent, clk, rst_n, halted && !result.valid, !result.valid)

    // an error transfer is the last one
    `NSDF_ASSERT_NXT(a_err_last, clk, rst_n,
        result.valid && result.ready && (result.kind == KIND_ERR), !result.valid)

    // error items always carry a code and the parser is halted behind them
    `NSDF_ASSERT_IMP(a_err_code, clk, rst_n, result.valid && (result.kind == KIND_ERR),
        (result.error_code != ERR_NONE) && halted)

endmodule

`default_nettype wire
